/* rtl/core/segment_map_insert_and_split_macros.svh */
// Assertion macros for the segment map core.
`ifndef SEGMENT_MAP_INSERT_AND_SPLIT_MACROS_SVH
`define SEGMENT_MAP_INSERT_AND_SPLIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SMIS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment map assertion failed");
// Next-cycle implication.
`define SMIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment map assertion failed");
`else
`define SMIS_ASSERT_NOW(label, ante, cons)
`define SMIS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/smis_pkg.sv */
package smis_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAULT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic [63:0] first;
        logic [63:0] last;
        logic [63:0] orig;
        logic [7:0]  src;
    } seg_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_NOP,
        S_A_RD,
        S_A_CHK,
        S_A_HEAD,
        S_A_NEW,
        S_A_REST,
        S_A_TAIL,
        S_A_FIN,
        S_R_EMPTY,
        S_R_SCAN,
        S_R_CHK,
        S_R_DEC,
        S_R_EMIT
    } state_t;

endpackage

/* rtl/core/smis_req_if.sv */
interface smis_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        space;
    logic [63:0] start_address;
    logic [63:0] end_address;
    logic [31:0] byte_count;
    logic [7:0]  source_tag;

    modport source (output valid, cmd, space, start_address, end_address, byte_count,
                    source_tag, input ready);
    modport sink (input valid, cmd, space, start_address, end_address, byte_count,
                  source_tag, output ready);
endinterface

/* rtl/core/smis_rsp_if.sv */
interface smis_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  chunk_source;
    logic [63:0] chunk_address;
    logic [63:0] chunk_offset;
    logic [31:0] chunk_length;
    logic        last;

    modport source (output valid, status, chunk_source, chunk_address, chunk_offset,
                    chunk_length, last, input ready);
    modport sink (input valid, status, chunk_source, chunk_address, chunk_offset,
                  chunk_length, last, output ready);
endinterface

/* rtl/core/segment_map_insert_and_split.sv */
// Channel  Dir   Word
// req      in    cmd, space, start_address, end_address, byte_count, source_tag
// rsp      out   status, chunk_source, chunk_address, chunk_offset, chunk_length, last
//
// An add walks each stored segment of its table from A_RD to A_REST, then ends in
// A_TAIL and A_FIN; the rebuilt table goes to the spare bank of the segment memory,
// one write port. A read passes segments by R_SCAN and R_CHK, emits chunks by R_DEC
// and R_EMIT; the entry that stops the scan is checked again for the next chunk.
// Reset clears the segment counts at once; no clearing pass is needed.
// A stalled rsp holds the result register; req is taken only when idle.
module segment_map_insert_and_split
    import smis_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    smis_req_if.sink   req,
    smis_rsp_if.source rsp
);

    smis_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

/* rtl/core/smis_mem.sv */
module smis_mem
    import smis_pkg::*;
#(
    parameter int AW = 6
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output seg_entry_t    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  seg_entry_t    wr_data
);

    seg_entry_t mem [0:(1 << AW)-1];

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

/* rtl/core/smis_ctrl.sv */
`include "segment_map_insert_and_split_macros.svh"
module smis_ctrl
    import smis_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    smis_req_if.sink  req,
    smis_rsp_if.source rsp
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int AW = IW + 2;
    localparam int PW = $clog2(MAX_SEGMENTS + 1);
    localparam int NW = $clog2(MAX_SEGMENTS + 3);
    localparam int KW = $clog2(MAX_SEGMENTS + 2);
    localparam logic [NW-1:0] N_MAX = NW'(MAX_SEGMENTS);
    localparam logic [KW-1:0] K_LIM = KW'(MAX_SEGMENTS + 1);

    state_t state_reg, state_next;
    logic        sp_reg, sp_next;
    logic [63:0] s_reg, s_next;
    logic [63:0] e_reg, e_next;
    logic [7:0]  tag_reg, tag_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [63:0] addr_reg, addr_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [NW-1:0] n_reg, n_next;
    logic        placed_reg, placed_next;
    seg_entry_t  cur_reg, cur_next;
    logic        cand_v_reg, cand_v_next;
    logic        flt_reg, flt_next;
    logic [63:0] room_reg, room_next;
    logic [KW-1:0] k_reg, k_next;
    logic [1:0]  bank_reg, bank_next;
    logic [PW-1:0] used_reg [2];
    logic [PW-1:0] used_next [2];

    logic        ov_reg, ov_next;
    logic [1:0]  st_reg, st_next;
    logic [7:0]  osrc_reg, osrc_next;
    logic [63:0] oaddr_reg, oaddr_next;
    logic [63:0] ooff_reg, ooff_next;
    logic [31:0] olen_reg, olen_next;
    logic        olast_reg, olast_next;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    seg_entry_t    rd_data, wr_data;

    logic can_emit, accept;
    logic lo, hi, ovl, tail_ok, full;
    logic [PW-1:0] used_sp;
    logic [31:0] n32;
    logic [63:0] addr_adv;

    smis_mem #(.AW(AW)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign can_emit  = !ov_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign used_sp   = used_reg[sp_reg];

    // Classify the current old entry against the new range
    assign lo      = cur_reg.last < s_reg;
    assign hi      = cur_reg.first > e_reg;
    assign ovl     = !lo && !hi;
    assign tail_ok = cur_reg.last > e_reg;
    assign full    = n_reg > N_MAX;

    // Chunk length and next address
    assign n32      = ({32'd0, cnt_reg - 32'd1} < room_reg) ? cnt_reg
                                                            : (room_reg[31:0] + 32'd1);
    assign addr_adv = addr_reg + {32'd0, n32};

    assign rsp.valid         = ov_reg;
    assign rsp.status        = st_reg;
    assign rsp.chunk_source  = osrc_reg;
    assign rsp.chunk_address = oaddr_reg;
    assign rsp.chunk_offset  = ooff_reg;
    assign rsp.chunk_length  = olen_reg;
    assign rsp.last          = olast_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_ADD)
                    begin
                        state_next = (req.end_address < req.start_address) ? S_ADD_NOP
                                                                             : S_A_RD;
                    end
                    else
                    begin
                        state_next = (req.byte_count == 32'd0) ? S_R_EMPTY : S_R_SCAN;
                    end
                end
            end
            S_ADD_NOP: if (can_emit) state_next = S_IDLE;
            S_A_RD:    state_next = (ptr_reg < used_sp) ? S_A_CHK : S_A_TAIL;
            S_A_CHK:   state_next = S_A_HEAD;
            S_A_HEAD:  state_next = S_A_NEW;
            S_A_NEW:   state_next = S_A_REST;
            S_A_REST:  state_next = S_A_RD;
            S_A_TAIL:  state_next = S_A_FIN;
            S_A_FIN:   if (can_emit) state_next = S_IDLE;
            S_R_EMPTY: if (can_emit) state_next = S_IDLE;
            S_R_SCAN:  state_next = (ptr_reg < used_sp) ? S_R_CHK : S_R_DEC;
            S_R_CHK:   state_next = (rd_data.first <= addr_reg) ? S_R_SCAN : S_R_DEC;
            S_R_DEC:   state_next = S_R_EMIT;
            S_R_EMIT:
            begin
                if (can_emit)
                begin
                    if (flt_reg || (n32 == cnt_reg) || (k_reg + KW'(1) == K_LIM))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_R_SCAN;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory access and result word
    always_comb
    begin
        sp_next      = sp_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        tag_next     = tag_reg;
        cnt_next     = cnt_reg;
        addr_next    = addr_reg;
        ptr_next     = ptr_reg;
        n_next       = n_reg;
        placed_next  = placed_reg;
        cur_next     = cur_reg;
        cand_v_next  = cand_v_reg;
        flt_next     = flt_reg;
        room_next    = room_reg;
        k_next       = k_reg;
        bank_next    = bank_reg;
        used_next[0] = used_reg[0];
        used_next[1] = used_reg[1];
        ov_next      = ov_reg && !rsp.ready;
        st_next      = st_reg;
        osrc_next    = osrc_reg;
        oaddr_next   = oaddr_reg;
        ooff_next    = ooff_reg;
        olen_next    = olen_reg;
        olast_next   = olast_reg;
        rd_en        = 1'b0;
        rd_addr      = {sp_reg, bank_reg[sp_reg], ptr_reg[IW-1:0]};
        wr_en        = 1'b0;
        wr_addr      = {sp_reg, ~bank_reg[sp_reg], n_reg[IW-1:0]};
        wr_data      = cur_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sp_next     = req.space;
                    s_next      = req.start_address;
                    e_next      = req.end_address;
                    tag_next    = req.source_tag;
                    cnt_next    = req.byte_count;
                    addr_next   = req.start_address;
                    ptr_next    = '0;
                    n_next      = '0;
                    placed_next = 1'b0;
                    cand_v_next = 1'b0;
                    k_next      = '0;
                end
            end
            S_ADD_NOP, S_R_EMPTY:
            begin
                if (can_emit)
                begin
                    ov_next    = 1'b1;
                    st_next    = ST_OK;
                    osrc_next  = 8'd0;
                    oaddr_next = (state_reg == S_R_EMPTY) ? addr_reg : 64'd0;
                    ooff_next  = 64'd0;
                    olen_next  = 32'd0;
                    olast_next = 1'b1;
                end
            end
            S_A_RD, S_R_SCAN:
            begin
                rd_en = ptr_reg < used_sp;
            end
            S_A_CHK:
            begin
                cur_next = rd_data;
            end
            // Keep the part of the old entry before the new range
            S_A_HEAD:
            begin
                if (ovl && (cur_reg.first < s_reg))
                begin
                    wr_en         = n_reg < N_MAX;
                    wr_data.first = cur_reg.first;
                    wr_data.last  = s_reg - 64'd1;
                    n_next        = n_reg + NW'(1);
                end
            end
            // Place the new range ahead of the first later piece
            S_A_NEW:
            begin
                if (!placed_reg && (hi || (ovl && tail_ok)))
                begin
                    wr_en         = n_reg < N_MAX;
                    wr_data.first = s_reg;
                    wr_data.last  = e_reg;
                    wr_data.orig  = s_reg;
                    wr_data.src   = tag_reg;
                    n_next        = n_reg + NW'(1);
                    placed_next   = 1'b1;
                end
            end
            // Copy the old entry whole, or its part after the new range
            S_A_REST:
            begin
                if (lo || hi || tail_ok)
                begin
                    wr_en = n_reg < N_MAX;
                    if (ovl)
                    begin
                        wr_data.first = e_reg + 64'd1;
                    end
                    n_next = n_reg + NW'(1);
                end
                ptr_next = ptr_reg + PW'(1);
            end
            S_A_TAIL:
            begin
                if (!placed_reg)
                begin
                    wr_en         = n_reg < N_MAX;
                    wr_data.first = s_reg;
                    wr_data.last  = e_reg;
                    wr_data.orig  = s_reg;
                    wr_data.src   = tag_reg;
                    n_next        = n_reg + NW'(1);
                    placed_next   = 1'b1;
                end
            end
            // Commit the rebuilt bank unless it overflowed
            S_A_FIN:
            begin
                if (can_emit)
                begin
                    if (!full)
                    begin
                        bank_next[sp_reg] = ~bank_reg[sp_reg];
                        used_next[sp_reg] = PW'(n_reg);
                    end
                    ov_next    = 1'b1;
                    st_next    = full ? ST_FULL : ST_OK;
                    osrc_next  = 8'd0;
                    oaddr_next = 64'd0;
                    ooff_next  = 64'd0;
                    olen_next  = 32'd0;
                    olast_next = 1'b1;
                end
            end
            S_R_CHK:
            begin
                if (rd_data.first <= addr_reg)
                begin
                    cur_next    = rd_data;
                    cand_v_next = 1'b1;
                    ptr_next    = ptr_reg + PW'(1);
                end
            end
            S_R_DEC:
            begin
                flt_next  = !cand_v_reg || (cur_reg.last < addr_reg);
                room_next = cur_reg.last - addr_reg;
            end
            S_R_EMIT:
            begin
                if (can_emit)
                begin
                    ov_next    = 1'b1;
                    oaddr_next = addr_reg;
                    if (flt_reg)
                    begin
                        st_next    = ST_FAULT;
                        osrc_next  = 8'd0;
                        ooff_next  = 64'd0;
                        olen_next  = 32'd0;
                        olast_next = 1'b1;
                    end
                    else
                    begin
                        st_next    = ST_OK;
                        osrc_next  = cur_reg.src;
                        ooff_next  = addr_reg - cur_reg.orig;
                        olen_next  = n32;
                        olast_next = (n32 == cnt_reg);
                        cnt_next   = cnt_reg - n32;
                        addr_next  = addr_adv;
                        k_next     = k_reg + KW'(1);
                        // Restart the walk after wrapping past the top
                        if (addr_adv == 64'd0)
                        begin
                            ptr_next    = '0;
                            cand_v_next = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bank_reg    <= '0;
            used_reg[0] <= '0;
            used_reg[1] <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            used_reg[0] <= used_next[0];
            used_reg[1] <= used_next[1];
            ov_reg      <= ov_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        sp_reg     <= sp_next;
        s_reg      <= s_next;
        e_reg      <= e_next;
        tag_reg    <= tag_next;
        cnt_reg    <= cnt_next;
        addr_reg   <= addr_next;
        ptr_reg    <= ptr_next;
        n_reg      <= n_next;
        placed_reg <= placed_next;
        cur_reg    <= cur_next;
        cand_v_reg <= cand_v_next;
        flt_reg    <= flt_next;
        room_reg   <= room_next;
        k_reg      <= k_next;
        st_reg     <= st_next;
        osrc_reg   <= osrc_next;
        oaddr_reg  <= oaddr_next;
        ooff_reg   <= ooff_next;
        olen_reg   <= olen_next;
        olast_reg  <= olast_next;
    end

    `SMIS_ASSERT_NOW(a_wr_only_add, wr_en, (state_reg == S_A_HEAD) || (state_reg == S_A_NEW) || (state_reg == S_A_REST) || (state_reg == S_A_TAIL))
    `SMIS_ASSERT_NOW(a_used_bound, 1'b1, (used_reg[0] <= PW'(MAX_SEGMENTS)) && (used_reg[1] <= PW'(MAX_SEGMENTS)))
    `SMIS_ASSERT_NEXT(a_bank_flip, (state_reg == S_A_FIN) && can_emit && !full, bank_reg[sp_reg] != $past(bank_reg[sp_reg]))
    `SMIS_ASSERT_NOW(a_full_add_only, ov_reg && (st_reg == ST_FULL), olast_reg && (olen_reg == 32'd0))

endmodule
